/* src/ppmbp_pkg.sv */
// ============================================================================
// ppmbp_pkg
// shared types, codes and arithmetic helpers of the ppm predictor set
// ============================================================================
package ppmbp_pkg;

    localparam int MAX_HIST_DEF     = 8;
    localparam int NUM_BRANCHES_DEF = 64;

    localparam int OP_W      = 2;
    localparam int ID_W      = 6;
    localparam int CNT_W     = 8;
    localparam int MISS_W    = 40;
    localparam int TOT_W     = 41;
    localparam int STAT_W    = 32;
    localparam int CFG_W     = 4;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 288;

    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_EVENT        = 2'd0;
    localparam t_op OP_REPORT_CLEAR = 2'd1;
    localparam t_op OP_REPORT       = 2'd2;

    localparam logic [APB_AW-1:0] ADDR_MAX_HISTORY = 3'd0;

    localparam logic signed [CNT_W-1:0] CNT_MAX       = 8'sd127;
    localparam logic signed [CNT_W-1:0] CNT_MIN       = -8'sd127;
    localparam logic signed [CNT_W-1:0] CNT_PRIV_INIT = -8'sd1;

    localparam logic [CFG_W-1:0]  MAXH_RESET = 4'd8;
    localparam logic [STAT_W-1:0] STAT_MAX   = {STAT_W{1'b1}};
    localparam logic [MISS_W-1:0] MISS_MAX   = {MISS_W{1'b1}};
    localparam logic [TOT_W-1:0]  TOT_MAX    = {TOT_W{1'b1}};

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WRAP,
        S_LOAD_RD,
        S_LOAD,
        S_PRED_RD,
        S_PRED_CHK,
        S_TRAIN_RD,
        S_TRAIN_WR,
        S_STAT_WR,
        S_REP_RD,
        S_REP_ACC,
        S_DONE
    } t_state;

    // step toward the outcome, saturate at +-127, never land on zero
    function automatic logic signed [CNT_W-1:0] sat_step(
        input logic signed [CNT_W-1:0] c,
        input logic                    tk
    );
        logic signed [CNT_W-1:0] r;
        r = c;
        if (tk) begin
            if (c < CNT_MAX) r = c + 8'sd1;
        end else begin
            if (c > CNT_MIN) r = c - 8'sd1;
        end
        if (r == 8'sd0) r = tk ? 8'sd1 : -8'sd1;
        return r;
    endfunction

    // min(x, n - x), zero when x exceeds n
    function automatic logic [STAT_W-1:0] fold(
        input logic [STAT_W-1:0] x,
        input logic [STAT_W-1:0] n
    );
        logic [STAT_W-1:0] rest;
        rest = (x > n) ? '0 : n - x;
        return (x < rest) ? x : rest;
    endfunction

    function automatic logic [TOT_W-1:0] sat_add(
        input logic [TOT_W-1:0]  acc,
        input logic [STAT_W-1:0] v
    );
        logic [TOT_W:0] sum;
        sum = {1'b0, acc} + {{(TOT_W+1-STAT_W){1'b0}}, v};
        return sum[TOT_W] ? TOT_MAX : sum[TOT_W-1:0];
    endfunction

endpackage

/* src/ppmbp_ram.sv */
// ============================================================================
// ppmbp_ram
// simple dual-port memory, one write and one registered read per cycle
// ============================================================================
module ppmbp_ram #(
    parameter int W  = 8,
    parameter int AW = 9,
    parameter int D  = 512
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/ppm_branch_predictor_set.sv */
// ============================================================================
// ppm_branch_predictor_set
// four ppm branch direction predictors (global/local history, shared/private
// tables) with per-branch statistics and folded interval reports
// ============================================================================
//
//  channel   | dir | handshake                     | payload
//  ----------+-----+-------------------------------+---------------------------------
//  s_*       | in  | s_tvalid / s_tready           | tdata: branch_id, taken; tuser: op
//  m_*       | out | m_tvalid / m_tready           | tdata: 4 guesses, 4 misses, 3 totals
//  apb       | in  | psel, penable, pwrite, pready | max_history at byte address 0
//
//  a branch event wraps the branch index, loads its statistics word and searches
//  from order top = min(max_history, MAX_HIST) downward, a read and a check per
//  order (the search stops once all four predictors have hit, or at order zero),
//  then trains upward with a read and a write per order, one table port per predictor
//  a report reads one statistics word per branch
//  after reset a clearing pass fills the private tables with -1 and zeroes
//  the shared tables and branch statistics;
//  s_tready stays low meanwhile, configuration writes are taken as ever
//  the result sits in an output register, so the next beat is taken while it waits
//
module ppm_branch_predictor_set #(
    parameter int MAX_HIST     = ppmbp_pkg::MAX_HIST_DEF,
    parameter int NUM_BRANCHES = ppmbp_pkg::NUM_BRANCHES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input beats
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ppmbp_pkg::S_TDATA_W-1:0]    s_tdata,  // branch_id[5:0], taken[6], pad
    input  logic [ppmbp_pkg::OP_W-1:0]         s_tuser,  // operation[1:0]
    // result beats
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ppmbp_pkg::M_TDATA_W-1:0]    m_tdata,  // guess gs,ls,gp,lp [3:0],
                                                         // misses gs,ls,gp,lp 40b each,
                                                         // branch, transition, taken
                                                         // totals 41b each, pad
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ppmbp_pkg::APB_AW-1:0]       paddr,
    input  logic [ppmbp_pkg::APB_DW-1:0]       pwdata,
    output logic [ppmbp_pkg::APB_DW-1:0]       prdata,
    output logic                               pready
);
    import ppmbp_pkg::*;

    localparam int AW     = MAX_HIST + 1;                      // slot address bits
    localparam int IW     = (NUM_BRANCHES > 1) ? $clog2(NUM_BRANCHES) : 1;
    localparam int PW     = IW + AW;                           // private table address
    localparam int OW     = $clog2(MAX_HIST + 1);              // order width
    localparam int CW     = (IW + 1 > ID_W) ? IW + 1 : ID_W;   // raw branch id width
    localparam int SW     = 3*STAT_W + 2 + MAX_HIST;           // statistics word
    localparam int PDEPTH = NUM_BRANCHES * (2**AW);
    localparam int TDEPTH = 2**AW;
    localparam int SDEPTH = 2**IW;
    localparam logic [PW-1:0] CLR_LAST = PW'(PDEPTH - 1);
    localparam logic [CW-1:0] NB_C     = CW'(NUM_BRANCHES);
    localparam logic [IW-1:0] B_LAST   = IW'(NUM_BRANCHES - 1);
    localparam logic [OW-1:0] TOP_MAX  = OW'(MAX_HIST);

    t_state r_state, n_state;

    logic [CFG_W-1:0]    r_maxh;
    logic [OW-1:0]       w_top;

    t_op                 r_op;
    logic                r_tk;
    logic [CW-1:0]       r_idw;
    logic [IW-1:0]       w_id;
    logic [MAX_HIST-1:0] r_gh;
    logic [SW-1:0]       r_stat;
    logic [MAX_HIST-1:0] w_lh;

    logic [OW-1:0]       r_ord;
    logic [3:0]          r_found;
    logic [3:0]          w_found_nx;
    logic [3:0]          r_hg;
    logic [OW-1:0]       r_hord [4];
    logic [MISS_W-1:0]   r_miss [4];

    logic [IW-1:0]       r_b;
    logic [TOT_W-1:0]    r_tb, r_tt, r_tkt;
    logic [PW-1:0]       r_clr;

    logic                r_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata;
    logic [M_TDATA_W-1:0] w_pack;
    logic                w_out_free;

    // predictor table ports: 0 global shared, 1 local shared, 2 global private,
    // 3 local private
    logic [AW-1:0]          w_slot_g, w_slot_l, w_mask;
    logic [3:0]             w_twe;
    logic signed [CNT_W-1:0] w_twd [4];
    logic signed [CNT_W-1:0] w_trd [4];
    logic [AW-1:0]          w_sh_wa [2];
    logic [AW-1:0]          w_sh_ra [2];
    logic [PW-1:0]          w_pr_wa [2];
    logic [PW-1:0]          w_pr_ra [2];

    // statistics memory port
    logic          w_s_we;
    logic [IW-1:0] w_s_wa, w_s_ra;
    logic [SW-1:0] w_s_wd, w_srd;

    // event statistics update
    logic [STAT_W-1:0] w_exec, w_tkc, w_flp;
    logic [1:0]        w_ld;
    logic [SW-1:0]     w_stat_new;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MAX_HISTORY) ? {{(APB_DW-CFG_W){1'b0}}, r_maxh} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maxh <= MAXH_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_MAX_HISTORY) begin
            r_maxh <= pwdata[CFG_W-1:0];
        end
    end

    // orders above MAX_HIST saturate
    assign w_top = (int'(r_maxh) > MAX_HIST) ? TOP_MAX : OW'(r_maxh);

    assign w_id = r_idw[IW-1:0];
    assign w_lh = r_stat[SW-1 -: MAX_HIST];

    // slot of order r_ord: (2^i - 1) + (hist & (2^i - 1))
    assign w_mask   = (AW'(1) << r_ord) - AW'(1);
    assign w_slot_g = w_mask + (AW'(r_gh) & w_mask);
    assign w_slot_l = w_mask + (AW'(w_lh) & w_mask);

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    ppmbp_ram #(.W(CNT_W), .AW(AW), .D(TDEPTH)) u_sh_glob (
        .i_clk(i_clk), .i_we(w_twe[0]), .i_waddr(w_sh_wa[0]), .i_wdata(w_twd[0]),
        .i_raddr(w_sh_ra[0]), .o_rdata(w_trd[0])
    );
    ppmbp_ram #(.W(CNT_W), .AW(AW), .D(TDEPTH)) u_sh_loc (
        .i_clk(i_clk), .i_we(w_twe[1]), .i_waddr(w_sh_wa[1]), .i_wdata(w_twd[1]),
        .i_raddr(w_sh_ra[1]), .o_rdata(w_trd[1])
    );
    ppmbp_ram #(.W(CNT_W), .AW(PW), .D(PDEPTH)) u_pr_glob (
        .i_clk(i_clk), .i_we(w_twe[2]), .i_waddr(w_pr_wa[0]), .i_wdata(w_twd[2]),
        .i_raddr(w_pr_ra[0]), .o_rdata(w_trd[2])
    );
    ppmbp_ram #(.W(CNT_W), .AW(PW), .D(PDEPTH)) u_pr_loc (
        .i_clk(i_clk), .i_we(w_twe[3]), .i_waddr(w_pr_wa[1]), .i_wdata(w_twd[3]),
        .i_raddr(w_pr_ra[1]), .o_rdata(w_trd[3])
    );
    ppmbp_ram #(.W(SW), .AW(IW), .D(SDEPTH)) u_stats (
        .i_clk(i_clk), .i_we(w_s_we), .i_waddr(w_s_wa), .i_wdata(w_s_wd),
        .i_raddr(w_s_ra), .o_rdata(w_srd)
    );

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_found_nx[k] = r_found[k] || (w_trd[k] != '0);
        end
    end

    assign w_out_free = !r_m_tvalid || m_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:    if (r_clr == CLR_LAST) n_state = S_IDLE;
            S_IDLE:     if (s_tvalid) n_state = (s_tuser == OP_EVENT) ? S_WRAP : S_REP_RD;
            S_WRAP:     if (r_idw < NB_C) n_state = S_LOAD_RD;
            S_LOAD_RD:  n_state = S_LOAD;
            S_LOAD:     n_state = S_PRED_RD;
            S_PRED_RD:  n_state = S_PRED_CHK;
            S_PRED_CHK: n_state = (&w_found_nx || r_ord == '0) ? S_TRAIN_RD : S_PRED_RD;
            S_TRAIN_RD: n_state = S_TRAIN_WR;
            S_TRAIN_WR: n_state = (r_ord == w_top) ? S_STAT_WR : S_TRAIN_RD;
            S_STAT_WR:  n_state = S_DONE;
            S_REP_RD:   n_state = S_REP_ACC;
            S_REP_ACC:  n_state = (r_b == B_LAST) ? S_DONE : S_REP_RD;
            S_DONE:     if (w_out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // memory controls
    // ------------------------------------------------------------------
    assign w_exec = r_stat[STAT_W-1:0];
    assign w_tkc  = r_stat[2*STAT_W-1:STAT_W];
    assign w_flp  = r_stat[3*STAT_W-1:2*STAT_W];
    assign w_ld   = r_stat[3*STAT_W+1:3*STAT_W];

    always_comb begin
        logic [STAT_W-1:0] e_n, t_n, f_n;
        e_n = (w_exec == STAT_MAX) ? w_exec : w_exec + STAT_W'(1);
        t_n = (r_tk && w_tkc != STAT_MAX) ? w_tkc + STAT_W'(1) : w_tkc;
        // transition only once a direction has been seen
        f_n = (w_ld[1] && w_ld[0] != r_tk && w_flp != STAT_MAX) ? w_flp + STAT_W'(1) : w_flp;
        w_stat_new = {(w_lh << 1) | MAX_HIST'(r_tk), 1'b1, r_tk, f_n, t_n, e_n};
    end

    always_comb begin
        w_twe = '0;
        for (int k = 0; k < 4; k++) w_twd[k] = sat_step(w_trd[k], r_tk);
        w_sh_wa[0] = w_slot_g;
        w_sh_wa[1] = w_slot_l;
        w_sh_ra[0] = w_slot_g;
        w_sh_ra[1] = w_slot_l;
        w_pr_wa[0] = {w_id, w_slot_g};
        w_pr_wa[1] = {w_id, w_slot_l};
        w_pr_ra[0] = {w_id, w_slot_g};
        w_pr_ra[1] = {w_id, w_slot_l};
        w_s_we = 1'b0;
        w_s_wa = w_id;
        w_s_wd = w_stat_new;
        w_s_ra = w_id;
        case (r_state)
            S_CLEAR: begin
                w_twe      = 4'b1111;
                w_twd[0]   = '0;
                w_twd[1]   = '0;
                w_twd[2]   = CNT_PRIV_INIT;
                w_twd[3]   = CNT_PRIV_INIT;
                w_sh_wa[0] = r_clr[AW-1:0];
                w_sh_wa[1] = r_clr[AW-1:0];
                w_pr_wa[0] = r_clr;
                w_pr_wa[1] = r_clr;
                w_s_we     = 1'b1;
                w_s_wa     = r_clr[IW-1:0];
                w_s_wd     = '0;
            end
            S_TRAIN_WR: begin
                // only the held order and above are trained
                for (int k = 0; k < 4; k++) w_twe[k] = (r_ord >= r_hord[k]);
            end
            S_STAT_WR: w_s_we = 1'b1;
            S_REP_RD:  w_s_ra = r_b;
            S_REP_ACC: begin
                // clearing keeps local history and last direction
                w_s_we = (r_op == OP_REPORT_CLEAR);
                w_s_wa = r_b;
                w_s_wd = {w_srd[SW-1:3*STAT_W], {(3*STAT_W){1'b0}}};
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_comb begin
        logic [TOT_W-1:0] tb, tt, tk;
        tb = (r_op == OP_EVENT) ? '0 : r_tb;
        tt = (r_op == OP_EVENT) ? '0 : r_tt;
        tk = (r_op == OP_EVENT) ? '0 : r_tkt;
        w_pack = {1'b0, tk, tt, tb, r_miss[3], r_miss[2], r_miss[1], r_miss[0], r_hg};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_gh       <= '0;
            r_hg       <= '0;
            r_found    <= '0;
            r_m_tvalid <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_hord[k] <= '0;
                r_miss[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_out_free) r_m_tvalid <= 1'b1;
            else if (m_tready) r_m_tvalid <= 1'b0;
            case (r_state)
                S_CLEAR: r_clr <= r_clr + PW'(1);
                S_IDLE: begin
                    if (s_tvalid) begin
                        r_op  <= s_tuser;
                        r_idw <= CW'(s_tdata[ID_W-1:0]);
                        r_tk  <= s_tdata[ID_W];
                        r_b   <= '0;
                        r_tb  <= '0;
                        r_tt  <= '0;
                        r_tkt <= '0;
                    end
                end
                S_WRAP: if (r_idw >= NB_C) r_idw <= r_idw - NB_C;
                S_LOAD: begin
                    r_stat  <= w_srd;
                    r_ord   <= w_top;
                    r_found <= '0;
                end
                S_PRED_CHK: begin
                    // longest order with a set counter wins
                    for (int k = 0; k < 4; k++) begin
                        if (!r_found[k] && w_trd[k] != '0) begin
                            r_hord[k] <= r_ord;
                            r_hg[k]   <= !w_trd[k][CNT_W-1];
                        end
                    end
                    r_found <= w_found_nx;
                    if (&w_found_nx || r_ord == '0) r_ord <= '0;
                    else r_ord <= r_ord - OW'(1);
                end
                S_TRAIN_WR: if (r_ord != w_top) r_ord <= r_ord + OW'(1);
                S_STAT_WR: begin
                    for (int k = 0; k < 4; k++) begin
                        if (r_hg[k] != r_tk && r_miss[k] != MISS_MAX)
                            r_miss[k] <= r_miss[k] + MISS_W'(1);
                    end
                    r_gh <= (r_gh << 1) | MAX_HIST'(r_tk);
                end
                S_REP_ACC: begin
                    r_tb  <= sat_add(r_tb, w_srd[STAT_W-1:0]);
                    r_tt  <= sat_add(r_tt, fold(w_srd[3*STAT_W-1:2*STAT_W],
                                                w_srd[STAT_W-1:0]));
                    r_tkt <= sat_add(r_tkt, fold(w_srd[2*STAT_W-1:STAT_W],
                                                 w_srd[STAT_W-1:0]));
                    r_b   <= r_b + IW'(1);
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_m_tdata  <= w_pack;
                        // interval clear after the report beat is formed
                        if (r_op == OP_REPORT_CLEAR) begin
                            for (int k = 0; k < 4; k++) r_miss[k] <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;

`ifndef SYNTHESIS
    a_no_table_write_in_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REP_RD || r_state == S_REP_ACC) |-> (w_twe == '0))
        else $error("predictor table written during a report");

    a_train_within_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRAIN_WR) |-> (r_ord <= w_top))
        else $error("training beyond the configured order");

    a_clear_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_tready)
        else $error("input taken during the clearing pass");

    a_done_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (m_tvalid && r_state == S_IDLE))
        else $error("finished item did not reach the output register");
`endif

endmodule

/* tb/tb_ppm_branch_predictor_set.sv */
// ============================================================================
// tb_ppm_branch_predictor_set
// self-checking bench for the ppm predictor set: branch events and reports
// are streamed in under random idling on both sides, a scoreboard class runs
// its own copy of the four predictors and the branch statistics, and every
// result beat is compared field by field against the oldest prediction
// ============================================================================
module tb_ppm_branch_predictor_set;
    import ppmbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB        = NUM_BRANCHES_DEF;
    localparam int MH        = MAX_HIST_DEF;
    localparam int TAB_SZ    = (1 << (MH + 1)) - 1;
    localparam int STALL_MAX = 200000;  // covers the clearing pass after reset
    localparam int TAIL_WAIT = 150;     // longer than one report or one event

    // one expected result beat
    typedef struct {
        logic [3:0]        guess;
        logic [MISS_W-1:0] miss [4];
        logic [TOT_W-1:0]  tot  [3];
    } t_result;

    // ------------------------------------------------------------------------
    // scoreboard: predictor copy plus the queue of pending results
    // ------------------------------------------------------------------------
    class ppm_outcome_board;
        int unsigned  max_hist_reg;
        int unsigned  glob_hist;
        int unsigned  loc_hist [NB];
        byte          sh_glob [TAB_SZ];
        byte          sh_loc  [TAB_SZ];
        byte          pv_glob [NB][TAB_SZ];
        byte          pv_loc  [NB][TAB_SZ];
        bit           held_guess [4];
        int unsigned  held_order [4];
        longint unsigned misses [4];
        bit           dir_seen [NB];
        bit           dir_last [NB];
        longint unsigned execs [NB];
        longint unsigned takens [NB];
        longint unsigned flips [NB];
        t_result      expected_results [$];
        int           errors;

        function new();
            max_hist_reg = MAXH_RESET;
            glob_hist    = 0;
            errors       = 0;
            for (int b = 0; b < NB; b++) begin
                loc_hist[b] = 0;
                dir_seen[b] = 0;
                dir_last[b] = 0;
                execs[b]    = 0;
                takens[b]   = 0;
                flips[b]    = 0;
                for (int s = 0; s < TAB_SZ; s++) begin
                    pv_glob[b][s] = -1;
                    pv_loc[b][s]  = -1;
                end
            end
            for (int s = 0; s < TAB_SZ; s++) begin
                sh_glob[s] = 0;
                sh_loc[s]  = 0;
            end
            for (int k = 0; k < 4; k++) begin
                held_guess[k] = 0;
                held_order[k] = 0;
                misses[k]     = 0;
            end
        endfunction

        function int unsigned slot(int unsigned order, int unsigned hist);
            int unsigned low;
            low = (1 << order) - 1;
            return low + (hist & low);
        endfunction

        // predictor k: 0 global shared, 1 local shared, 2 global private, 3 local private
        function int rd_cnt(int k, int id, int unsigned s);
            case (k)
                0:       return sh_glob[s];
                1:       return sh_loc[s];
                2:       return pv_glob[id][s];
                default: return pv_loc[id][s];
            endcase
        endfunction

        function void wr_cnt(int k, int id, int unsigned s, int v);
            case (k)
                0:       sh_glob[s]     = byte'(v);
                1:       sh_loc[s]      = byte'(v);
                2:       pv_glob[id][s] = byte'(v);
                default: pv_loc[id][s]  = byte'(v);
            endcase
        endfunction

        function longint unsigned fold_stat(longint unsigned x, longint unsigned n);
            longint unsigned rest;
            rest = (x > n) ? 0 : n - x;
            return (x < rest) ? x : rest;
        endfunction

        function void note_beat(t_op op, int id, bit tk);
            int unsigned top;
            int unsigned hist [4];
            int c;
            int unsigned s;
            longint unsigned sums [3];
            t_result r;
            top = (max_hist_reg > MH) ? MH : max_hist_reg;
            sums = '{0, 0, 0};
            if (op == OP_EVENT) begin
                hist = '{glob_hist, loc_hist[id], glob_hist, loc_hist[id]};
                // search from the longest order down for a set counter
                for (int k = 0; k < 4; k++) begin
                    for (int i = top; i >= 0; i--) begin
                        c = rd_cnt(k, id, slot(i, hist[k]));
                        if (c != 0) begin
                            held_order[k] = i;
                            held_guess[k] = (c > 0);
                            break;
                        end
                    end
                end
                if (dir_seen[id] && dir_last[id] != tk && flips[id] < 32'hFFFF_FFFF)
                    flips[id]++;
                dir_seen[id] = 1;
                dir_last[id] = tk;
                if (execs[id] < 32'hFFFF_FFFF) execs[id]++;
                if (tk && takens[id] < 32'hFFFF_FFFF) takens[id]++;
                for (int k = 0; k < 4; k++) begin
                    if (held_guess[k] != tk && misses[k] < MISS_MAX) misses[k]++;
                    // held order above top trains nothing
                    for (int unsigned i = held_order[k]; i <= top; i++) begin
                        s = slot(i, hist[k]);
                        c = rd_cnt(k, id, s);
                        if (tk) begin
                            if (c < 127) c++;
                        end else begin
                            if (c > -127) c--;
                        end
                        if (c == 0) c = tk ? 1 : -1;
                        wr_cnt(k, id, s, c);
                    end
                end
                glob_hist    = ((glob_hist << 1) | tk) & ((1 << MH) - 1);
                loc_hist[id] = ((loc_hist[id] << 1) | tk) & ((1 << MH) - 1);
            end else begin
                for (int b = 0; b < NB; b++) begin
                    if (execs[b] > 0) begin
                        sums[0] += execs[b];
                        sums[1] += fold_stat(flips[b], execs[b]);
                        sums[2] += fold_stat(takens[b], execs[b]);
                    end
                end
                for (int j = 0; j < 3; j++)
                    if (sums[j] > TOT_MAX) sums[j] = TOT_MAX;
            end
            for (int k = 0; k < 4; k++) begin
                r.guess[k] = held_guess[k];
                r.miss[k]  = MISS_W'(misses[k]);
            end
            for (int j = 0; j < 3; j++) r.tot[j] = TOT_W'(sums[j]);
            expected_results.push_back(r);
            // interval clear keeps tables, histories and held values
            if (op == OP_REPORT_CLEAR) begin
                for (int k = 0; k < 4; k++) misses[k] = 0;
                for (int b = 0; b < NB; b++) begin
                    execs[b]  = 0;
                    takens[b] = 0;
                    flips[b]  = 0;
                end
            end
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_beat(logic [M_TDATA_W-1:0] d);
            t_result r;
            if (expected_results.size() == 0) begin
                report("unexpected result beat", d[63:0], 0);
                return;
            end
            r = expected_results.pop_front();
            for (int k = 0; k < 4; k++) begin
                if (d[k] !== r.guess[k])
                    report($sformatf("guess %0d", k), d[k], r.guess[k]);
                if (d[4+40*k +: 40] !== r.miss[k])
                    report($sformatf("misses %0d", k), d[4+40*k +: 40], r.miss[k]);
            end
            for (int j = 0; j < 3; j++)
                if (d[164+41*j +: 41] !== r.tot[j])
                    report($sformatf("total %0d", j), d[164+41*j +: 41], r.tot[j]);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, dut
    // ------------------------------------------------------------------------
    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;   // branch_id[5:0], taken[6], pad
    logic [OP_W-1:0]       s_tuser = OP_EVENT;  // operation[1:0]
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [M_TDATA_W-1:0]  m_tdata;        // guesses[3:0], 4 misses, 3 totals, pad
    logic                  psel = 0;
    logic                  penable = 0;
    logic                  pwrite = 0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    always #4 i_clk = ~i_clk;

    ppm_branch_predictor_set i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ppm_outcome_board board = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles  = 0;
    bit pattern [NB][8];   // per-branch repeating direction pattern
    int pat_len [NB];
    int pat_pos [NB];

    // ------------------------------------------------------------------------
    // result side: random backpressure at the falling edge, check at the rising
    // ------------------------------------------------------------------------
    always @(negedge i_clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk)
        if (m_tvalid && m_tready) board.check_beat(m_tdata);

    // watchdog: cycles without any accepted beat or register write
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pwrite && pready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_MAX) begin
            $display("tb_ppm_branch_predictor_set NOT OK");
            $finish;
        end else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task send_beat(t_op op, int id, bit tk);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(negedge i_clk);
        end
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, tk, 6'(id)};
        do @(posedge i_clk); while (!s_tready);
        board.note_beat(op, id, tk);
    endtask

    task write_max_history(int unsigned v);
        @(negedge i_clk);
        s_tvalid <= 0;
        psel     <= 1;
        pwrite   <= 1;
        penable  <= 0;
        paddr    <= ADDR_MAX_HISTORY;
        pwdata   <= v;
        @(negedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        board.max_hist_reg = v & 4'hF;
        @(negedge i_clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
    endtask

    // let every pending result arrive, then give the block time to settle
    task drain();
        @(negedge i_clk);
        s_tvalid <= 0;
        while (board.expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
    endtask

    // mostly patterned branch behavior so histories carry information
    task random_beat();
        int id;
        int r;
        bit tk;
        r  = $urandom_range(99);
        id = ($urandom_range(3) == 0) ? $urandom_range(NB - 1) : $urandom_range(7);
        if (r < 4) send_beat(OP_REPORT, $urandom_range(NB - 1), $urandom_range(1));
        else if (r < 7) send_beat(OP_REPORT_CLEAR, $urandom_range(NB - 1), $urandom_range(1));
        else begin
            if ($urandom_range(9) < 8) begin
                tk = pattern[id][pat_pos[id]];
                pat_pos[id] = (pat_pos[id] + 1) % pat_len[id];
            end else
                tk = $urandom_range(1);
            send_beat(OP_EVENT, id, tk);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    int unsigned hist_plan [7] = '{8, 2, 0, 15, 5, 1, 8};

    initial begin
        for (int b = 0; b < NB; b++) begin
            pat_len[b] = $urandom_range(8, 1);
            pat_pos[b] = 0;
            for (int j = 0; j < 8; j++) pattern[b][j] = $urandom_range(1);
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        write_max_history(MAXH_RESET);

        // directed: extreme ids, both directions, every operation
        send_beat(OP_REPORT, 0, 0);
        send_beat(OP_EVENT, 0, 1);
        send_beat(OP_EVENT, 63, 0);
        send_beat(OP_EVENT, 63, 1);
        send_beat(OP_EVENT, 0, 0);
        for (int i = 0; i < 8; i++) send_beat(OP_EVENT, 5, i[0]);  // alternating
        for (int i = 0; i < 4; i++) send_beat(OP_EVENT, 42, 1);
        send_beat(OP_REPORT, 63, 1);
        send_beat(OP_REPORT_CLEAR, 0, 0);
        send_beat(OP_REPORT, 0, 0);
        send_beat(OP_EVENT, 5, 1);
        drain();
        // shrink the order below the held ones, then train at order zero
        write_max_history(0);
        send_beat(OP_EVENT, 5, 0);
        send_beat(OP_EVENT, 42, 0);
        send_beat(OP_REPORT, 1, 0);
        drain();

        // random phases over several history lengths and idling modes
        for (int p = 0; p < 7; p++) begin
            write_max_history(hist_plan[p]);
            case (p % 3)
                0: begin send_idle_pct = 7;  recv_idle_pct = 61; end
                1: begin send_idle_pct = 61; recv_idle_pct = 7;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int n = 0; n < 200; n++) random_beat();
            drain();
        end
        send_beat(OP_REPORT_CLEAR, 0, 0);
        drain();

        if (board.errors == 0)
            $display("tb_ppm_branch_predictor_set OK");
        else
            $display("tb_ppm_branch_predictor_set NOT OK");
        $finish;
    end

endmodule

/* sim.f */
src/ppmbp_pkg.sv
src/ppmbp_ram.sv
src/ppm_branch_predictor_set.sv
tb/tb_ppm_branch_predictor_set.sv
